FILE: src/ssc_pkg.sv
// ============================================================================
// Sparse-set component store package
// Shared item types, action and status codes, and the engine state encoding.
// ============================================================================
package ssc_pkg;

    // Action codes carried by an input request.
    localparam logic [2:0] ACT_CREATE  = 3'd0;
    localparam logic [2:0] ACT_DESTROY = 3'd1;
    localparam logic [2:0] ACT_ADD     = 3'd2;
    localparam logic [2:0] ACT_REMOVE  = 3'd3;
    localparam logic [2:0] ACT_FIND    = 3'd4;
    localparam logic [2:0] ACT_VALID   = 3'd5;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_MISS  = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_NOENT = 2'd3;

    // Input request as it arrives on the ports.
    typedef struct packed {
        logic [2:0]  action;
        logic [9:0]  ent_id;
        logic [1:0]  pool_index;
        logic [31:0] data_in;
    } in_item_t;

    // Result as it leaves on the ports.
    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [9:0]  new_entity;
        logic [7:0]  slot;
        logic [31:0] data_out;
    } out_item_t;

    // Classified operation handed from the front to the engine.
    typedef enum logic [2:0] {
        OP_CREATE,
        OP_DESTROY,
        OP_ADD,
        OP_REMOVE,
        OP_FIND,
        OP_VALID,
        OP_REJECT,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [9:0]  ent_id;
        logic [1:0]  pool_index;
        logic [31:0] data_in;
    } cmd_t;

    // Engine states.
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_POP,
        BK_CWR,
        BK_ROW,
        BK_SEL,
        BK_DENSE,
        BK_LAST,
        BK_MOVER,
        BK_FREE,
        BK_DONE
    } bk_state_t;

endpackage

FILE: src/ssc_front.sv
// ============================================================================
// Sparse-set store front end
// Accepts requests, checks ranges, classifies them and queues them for the
// engine in a two-entry command queue.
// ============================================================================
module ssc_front
    import ssc_pkg::*;
#(
    parameter int MAX_ENTITIES = 1024,
    parameter int NUM_POOLS    = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t in_item,
    input  logic     clearing,
    output logic     cmd_valid,
    input  logic     cmd_pop,
    output cmd_t     cmd
);

    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    cmd_t       q_mem [2];
    cmd_t       cls;
    logic       e_ok, p_ok, take, give;

    // Range checks and classification of the incoming request.
    assign e_ok = 32'(in_item.ent_id) < MAX_ENTITIES;
    assign p_ok = 32'(in_item.pool_index) < NUM_POOLS;

    always_comb
    begin
        cls.ent_id     = in_item.ent_id;
        cls.pool_index = in_item.pool_index;
        cls.data_in    = in_item.data_in;
        case (in_item.action)
            ACT_CREATE:  cls.op = OP_CREATE;
            ACT_DESTROY: cls.op = e_ok ? OP_DESTROY : OP_REJECT;
            ACT_ADD:     cls.op = (e_ok && p_ok) ? OP_ADD : OP_REJECT;
            ACT_REMOVE:  cls.op = (e_ok && p_ok) ? OP_REMOVE : OP_REJECT;
            ACT_FIND:    cls.op = (e_ok && p_ok) ? OP_FIND : OP_REJECT;
            ACT_VALID:   cls.op = e_ok ? OP_VALID : OP_REJECT;
            default:     cls.op = OP_NONE;
        endcase
    end

    // Queue control; no request is taken while the tables are being cleared.
    assign full      = (cnt_reg == 2'd2) || clearing;
    assign take      = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign give      = cmd_pop && cmd_valid;
    assign cmd       = q_mem[rd_reg];

    always_comb
    begin
        wr_next  = take ? !wr_reg : wr_reg;
        rd_next  = give ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(take) - 2'(give);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            q_mem[wr_reg] <= cls;
        end
    end

endmodule

FILE: src/ssc_outq.sv
// ============================================================================
// Sparse-set store result queue
// Two-entry queue that holds finished results until they are popped.
// ============================================================================
module ssc_outq
    import ssc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_valid,
    output logic      res_ready,
    input  out_item_t res,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    out_item_t  q_mem [2];
    logic       take, give;

    // Queue control.
    assign res_ready = (cnt_reg != 2'd2);
    assign take      = res_valid && res_ready;
    assign empty     = (cnt_reg == 2'd0);
    assign give      = pop && !empty;
    assign out_item  = q_mem[rd_reg];

    always_comb
    begin
        wr_next  = take ? !wr_reg : wr_reg;
        rd_next  = give ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(take) - 2'(give);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            q_mem[wr_reg] <= res;
        end
    end

endmodule

FILE: src/ssc_back.sv
// ============================================================================
// Sparse-set store engine
// Carries out classified requests against the entity row table, the dense
// pool table and the free-id stack, one request at a time.
// ============================================================================
module ssc_back
    import ssc_pkg::*;
#(
    parameter int MAX_ENTITIES = 1024,
    parameter int NUM_POOLS    = 4,
    parameter int POOL_DEPTH   = 256,
    parameter int DATA_WIDTH   = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [8:0] pool_limit,
    output logic      clearing,
    input  logic      cmd_valid,
    output logic      cmd_pop,
    input  cmd_t      cmd,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res
);

    localparam int ENT_W = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int FC_W  = $clog2(MAX_ENTITIES + 1);
    localparam int PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int SW    = $clog2(POOL_DEPTH);
    localparam int CW    = $clog2(POOL_DEPTH + 1);
    localparam int ROW_W = 1 + NUM_POOLS * SW;
    localparam int DN    = NUM_POOLS * POOL_DEPTH;
    localparam int DAW   = $clog2(DN);
    localparam int DW    = ENT_W + DATA_WIDTH;

    bk_state_t state_reg, state_next;
    cmd_t      cmd_reg, cmd_next;
    out_item_t res_reg, res_next;
    logic [PW-1:0]    pc_reg, pc_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [ENT_W-1:0] mover_reg, mover_next;
    logic [ENT_W-1:0] id_reg, id_next;
    logic [FC_W-1:0]  fc_reg, fc_next;
    logic [FC_W-1:0]  low_reg, low_next;
    logic [CW-1:0]    cnt_reg [NUM_POOLS];
    logic [CW-1:0]    cnt_next [NUM_POOLS];
    logic             clr_reg;
    logic [ENT_W-1:0] clr_addr_reg;

    // Tables.
    logic [ROW_W-1:0] row_mem [MAX_ENTITIES];
    logic [DW-1:0]    dense_mem [DN];
    logic [ENT_W-1:0] stack_mem [MAX_ENTITIES];
    logic [ROW_W-1:0] row_q;
    logic [DW-1:0]    dense_q;
    logic [ENT_W-1:0] stack_q;

    logic [ENT_W-1:0] row_raddr, row_waddr;
    logic             row_we;
    logic [ROW_W-1:0] row_wdata;
    logic [DAW-1:0]   dense_raddr, dense_waddr;
    logic             dense_we;
    logic [DW-1:0]    dense_wdata;
    logic             stack_we;

    logic [ENT_W-1:0] e_in, e_cur, owner_q, id_pick;
    logic [CW-1:0]    cnt_cur;
    logic [SW-1:0]    sparse_cur;
    logic             pool_full, member, last_pool, from_stack, take;

    // Shared decode of the current request.
    assign e_in       = ENT_W'(cmd.ent_id);
    assign e_cur      = ENT_W'(cmd_reg.ent_id);
    assign cnt_cur    = cnt_reg[pc_reg];
    assign sparse_cur = row_reg[32'(pc_reg) * SW +: SW];
    assign owner_q    = dense_q[DW-1 -: ENT_W];
    assign pool_full  = (32'(cnt_cur) >= 32'(pool_limit)) || (32'(cnt_cur) >= POOL_DEPTH);
    assign member     = (32'(slot_reg) < 32'(cnt_cur)) && (owner_q == e_cur);
    assign last_pool  = (32'(pc_reg) == NUM_POOLS - 1);
    assign from_stack = (fc_reg > low_reg);
    assign id_pick    = from_stack ? stack_q : ENT_W'(FC_W'(MAX_ENTITIES) - low_reg);
    assign take       = (state_reg == BK_IDLE) && cmd_valid && !clr_reg;

    assign clearing  = clr_reg;
    assign cmd_pop   = take;
    assign res_valid = (state_reg == BK_DONE);
    assign res       = res_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (take)
                begin
                    case (cmd.op)
                        OP_CREATE:  state_next = (fc_reg == '0) ? BK_DONE : BK_POP;
                        OP_REJECT:  state_next = BK_DONE;
                        OP_NONE:    state_next = BK_DONE;
                        default:    state_next = BK_ROW;
                    endcase
                end
            end
            BK_POP:   state_next = BK_CWR;
            BK_CWR:   state_next = BK_DONE;
            BK_ROW:
            begin
                case (cmd_reg.op)
                    OP_DESTROY: state_next = row_q[ROW_W-1] ? BK_SEL : BK_DONE;
                    OP_ADD:     state_next = pool_full ? BK_DONE : BK_SEL;
                    OP_REMOVE:  state_next = BK_SEL;
                    OP_FIND:    state_next = BK_SEL;
                    default:    state_next = BK_DONE;
                endcase
            end
            BK_SEL:   state_next = BK_DENSE;
            BK_DENSE:
            begin
                if (member && (cmd_reg.op == OP_REMOVE || cmd_reg.op == OP_DESTROY))
                begin
                    state_next = BK_LAST;
                end
                else if (cmd_reg.op == OP_DESTROY)
                begin
                    state_next = last_pool ? BK_FREE : BK_SEL;
                end
                else
                begin
                    state_next = BK_DONE;
                end
            end
            BK_LAST:  state_next = BK_MOVER;
            BK_MOVER:
            begin
                if (cmd_reg.op == OP_DESTROY)
                begin
                    state_next = last_pool ? BK_FREE : BK_SEL;
                end
                else
                begin
                    state_next = BK_DONE;
                end
            end
            BK_FREE:  state_next = BK_DONE;
            BK_DONE:  state_next = res_ready ? BK_IDLE : BK_DONE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // Datapath, table accesses and result.
    always_comb
    begin
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        pc_next    = pc_reg;
        row_next   = row_reg;
        slot_next  = slot_reg;
        mover_next = mover_reg;
        id_next    = id_reg;
        fc_next    = fc_reg;
        low_next   = low_reg;
        cnt_next   = cnt_reg;

        row_raddr   = e_in;
        row_we      = 1'b0;
        row_waddr   = e_cur;
        row_wdata   = row_reg;
        dense_raddr = DAW'(32'(pc_reg) * POOL_DEPTH + 32'(sparse_cur));
        dense_we    = 1'b0;
        dense_waddr = DAW'(32'(pc_reg) * POOL_DEPTH + 32'(slot_reg));
        dense_wdata = dense_q;
        stack_we    = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (take)
                begin
                    cmd_next = cmd;
                    res_next = '0;
                    pc_next  = PW'(cmd.pool_index);
                    if (cmd.op == OP_REJECT)
                    begin
                        res_next.status = STAT_MISS;
                    end
                    else if (cmd.op == OP_CREATE && fc_reg == '0)
                    begin
                        res_next.status = STAT_NOENT;
                    end
                end
            end
            BK_POP:
            begin
                // Pushed-back ids sit above the never-issued ones.
                id_next   = id_pick;
                row_raddr = id_pick;
                fc_next   = fc_reg - 1'b1;
                if (!from_stack)
                begin
                    low_next = low_reg - 1'b1;
                end
            end
            BK_CWR:
            begin
                row_we                = 1'b1;
                row_waddr             = id_reg;
                row_wdata             = row_q;
                row_wdata[ROW_W-1]    = 1'b1;
                res_next.new_entity   = 10'(id_reg);
            end
            BK_ROW:
            begin
                row_next = row_q;
                case (cmd_reg.op)
                    OP_VALID:   res_next.found = row_q[ROW_W-1];
                    OP_DESTROY:
                    begin
                        pc_next = '0;
                        if (!row_q[ROW_W-1])
                        begin
                            res_next.status = STAT_MISS;
                        end
                    end
                    OP_ADD:
                    begin
                        if (pool_full)
                        begin
                            res_next.status = STAT_FULL;
                        end
                    end
                    default: ;
                endcase
            end
            BK_SEL:
            begin
                slot_next = sparse_cur;
            end
            BK_DENSE:
            begin
                dense_raddr = DAW'(32'(pc_reg) * POOL_DEPTH + 32'(cnt_cur) - 1);
                case (cmd_reg.op)
                    OP_FIND:
                    begin
                        if (member)
                        begin
                            res_next.found    = 1'b1;
                            res_next.slot     = 8'(slot_reg);
                            res_next.data_out = 32'(dense_q[DATA_WIDTH-1:0]);
                        end
                        else
                        begin
                            res_next.status = STAT_MISS;
                        end
                    end
                    OP_ADD:
                    begin
                        if (member)
                        begin
                            res_next.status = STAT_MISS;
                            res_next.slot   = 8'(slot_reg);
                        end
                        else
                        begin
                            dense_we    = 1'b1;
                            dense_waddr = DAW'(32'(pc_reg) * POOL_DEPTH + 32'(cnt_cur));
                            dense_wdata = {e_cur, DATA_WIDTH'(cmd_reg.data_in)};
                            row_we      = 1'b1;
                            row_waddr   = e_cur;
                            row_wdata   = row_reg;
                            row_wdata[32'(pc_reg) * SW +: SW] = SW'(cnt_cur);
                            cnt_next[pc_reg] = cnt_cur + 1'b1;
                            res_next.slot    = 8'(cnt_cur);
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!member)
                        begin
                            res_next.status = STAT_MISS;
                        end
                    end
                    OP_DESTROY:
                    begin
                        if (!member && !last_pool)
                        begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            BK_LAST:
            begin
                // Move the last member into the gap.
                dense_we         = 1'b1;
                dense_wdata      = dense_q;
                mover_next       = owner_q;
                row_raddr        = owner_q;
                cnt_next[pc_reg] = cnt_cur - 1'b1;
            end
            BK_MOVER:
            begin
                row_we    = 1'b1;
                row_waddr = mover_reg;
                row_wdata = row_q;
                row_wdata[32'(pc_reg) * SW +: SW] = slot_reg;
                if (cmd_reg.op == OP_DESTROY && !last_pool)
                begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            BK_FREE:
            begin
                row_we             = 1'b1;
                row_waddr          = e_cur;
                row_wdata          = row_reg;
                row_wdata[ROW_W-1] = 1'b0;
                if (32'(fc_reg) < MAX_ENTITIES)
                begin
                    stack_we = 1'b1;
                    fc_next  = fc_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            fc_reg       <= FC_W'(MAX_ENTITIES);
            low_reg      <= FC_W'(MAX_ENTITIES);
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            for (int i = 0; i < NUM_POOLS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            fc_reg    <= fc_next;
            low_reg   <= low_next;
            cnt_reg   <= cnt_next;
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (32'(clr_addr_reg) == MAX_ENTITIES - 1)
                begin
                    clr_reg <= 1'b0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        pc_reg    <= pc_next;
        row_reg   <= row_next;
        slot_reg  <= slot_next;
        mover_reg <= mover_next;
        id_reg    <= id_next;
    end

    // Entity row table: alive flag and sparse slot per pool; cleared after reset.
    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            row_mem[clr_addr_reg] <= '0;
        end
        else if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        row_q <= row_mem[row_raddr];
    end

    // Dense owner and data table.
    always_ff @(posedge clk)
    begin
        if (dense_we)
        begin
            dense_mem[dense_waddr] <= dense_wdata;
        end
        dense_q <= dense_mem[dense_raddr];
    end

    // Free-id stack of pushed-back ids.
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[ENT_W'(fc_reg)] <= e_cur;
        end
        stack_q <= stack_mem[ENT_W'(fc_reg - 1'b1)];
    end

    // The free count never exceeds the number of ids.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(fc_reg) <= MAX_ENTITIES)
        else $error("free count above id range");

    // Never-issued ids always lie below the stack top.
    assert property (@(posedge clk) disable iff (!rst_n)
        low_reg <= fc_reg)
        else $error("fresh id mark above free count");

    // A gap fill only happens in a pool that has members.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_LAST |-> cnt_cur != '0)
        else $error("gap fill in empty pool");

    // No request is taken while the row table is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> state_reg == BK_IDLE)
        else $error("engine active during clearing pass");

    // The pool in use never holds more members than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != BK_IDLE |-> 32'(cnt_cur) <= POOL_DEPTH)
        else $error("pool count above depth");

endmodule

FILE: src/sparse_set_component_store_unit.sv
// ============================================================================
// Sparse-set component store
// Entity allocator with a free-id stack and several sparse-set pools.
// ============================================================================
//
//  Channel   Signals                    Moves
//  input     push, full, in_item        one request per accepted push
//  result    empty, pop, out_item       one result per request, in order
//  config    cfg_valid, cfg_ready,      pool_limit write, always ready
//            cfg_data
//
// Each request is carried out as a walk of engine states; destroy visits
// every pool and takes extra steps in each pool that holds the entity.
// The walk follows the single-ported registered reads of the row and
// dense tables.
// After reset a clearing pass zeroes the row table; full stays high during
// it. A stalled result side holds the engine once the result queue is full;
// the input queue keeps taking requests until its two entries are full.
//
module sparse_set_component_store_unit
    import ssc_pkg::*;
#(
    parameter int MAX_ENTITIES = 1024,
    parameter int NUM_POOLS    = 4,
    parameter int POOL_DEPTH   = 256,
    parameter int DATA_WIDTH   = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_item_t   in_item,
    output logic       empty,
    input  logic       pop,
    output out_item_t  out_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data
);

    logic [8:0] limit_reg;
    logic       clearing, cmd_valid, cmd_pop, res_valid, res_ready;
    cmd_t       cmd;
    out_item_t  res;

    // Pool limit register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Front end: request intake and classification.
    ssc_front #(
        .MAX_ENTITIES(MAX_ENTITIES),
        .NUM_POOLS(NUM_POOLS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .in_item(in_item),
        .clearing(clearing),
        .cmd_valid(cmd_valid),
        .cmd_pop(cmd_pop),
        .cmd(cmd)
    );

    // Engine: table accesses.
    ssc_back #(
        .MAX_ENTITIES(MAX_ENTITIES),
        .NUM_POOLS(NUM_POOLS),
        .POOL_DEPTH(POOL_DEPTH),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .pool_limit(limit_reg),
        .clearing(clearing),
        .cmd_valid(cmd_valid),
        .cmd_pop(cmd_pop),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res)
    );

    // Result queue.
    ssc_outq u_outq (
        .clk(clk),
        .rst_n(rst_n),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res),
        .empty(empty),
        .pop(pop),
        .out_item(out_item)
    );

endmodule
